// ===== rtl/core/brn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brn_pkg
// Shared widths, constants and codes of the bilinear resize and normalize core.
// ----------------------------------------------------------------------------
package brn_pkg;

	localparam int CH_W    = 8;
	localparam int PIX_W   = 3 * CH_W;
	localparam int FRAC_W  = 16;
	localparam int QUERY_W = 10;
	localparam int RATIO_W = 24;
	localparam int SIZE_W  = 8;
	localparam int TGT_W   = 11;
	localparam int PLANE_W = 20;
	localparam int LOAD_W  = 7;
	localparam int CFG_W   = 24;
	localparam int CFG_IDX_W = 3;

	localparam logic [FRAC_W:0]   ONE_Q16    = 17'h10000;
	localparam logic [FRAC_W-1:0] HALF_Q16   = 16'h8000;
	localparam logic [8:0]        NORM_SCALE = 9'd257;

	localparam logic CMD_WRITE   = 1'b0;
	localparam logic CMD_COMPUTE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_COLS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_ROWS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COL_RATIO     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_RATIO     = 3'd5;

endpackage

// ===== rtl/core/brn_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brn_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module brn_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/brn_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brn_axis
// Two-stage mapping of one output coordinate to two clamped source indices
// and a 16-bit interpolation weight.
// ----------------------------------------------------------------------------
module brn_axis import brn_pkg::*; #(
	parameter int MAX_SIZE = 128,
	localparam int IDX_W = $clog2(MAX_SIZE)
) (
	input  logic               clk,
	input  logic [QUERY_W-1:0] q,
	input  logic [RATIO_W-1:0] ratio,
	input  logic [SIZE_W-1:0]  size_cfg,
	output logic [IDX_W-1:0]   idx0,
	output logic [IDX_W-1:0]   idx1,
	output logic [FRAC_W-1:0]  frac
);

	localparam int CW = ($clog2(MAX_SIZE + 1) > SIZE_W) ? $clog2(MAX_SIZE + 1) : SIZE_W;
	localparam int T_W = QUERY_W + 1 + RATIO_W;
	localparam int POS_W = T_W - 1;
	localparam int IPART_W = POS_W - FRAC_W;

	logic [T_W-1:0]     t_s1;
	logic               neg;
	logic [POS_W-1:0]   pos;
	logic [IPART_W-1:0] ipart;
	logic [IPART_W:0]   ipart_inc;
	logic [IPART_W:0]   lim_ext;
	logic [FRAC_W-1:0]  fpart;
	logic [CW-1:0]      size_c;
	logic [CW-1:0]      lim;

	always_ff @(posedge clk) begin
		t_s1 <= T_W'({q, 1'b1}) * T_W'(ratio);
	end

	always_comb begin
		neg = (t_s1 < T_W'(ONE_Q16));
		pos = POS_W'((t_s1 - T_W'(ONE_Q16)) >> 1);
		ipart = neg ? '0 : pos[POS_W-1:FRAC_W];
		fpart = neg ? '0 : pos[FRAC_W-1:0];
		ipart_inc = {1'b0, ipart} + (IPART_W + 1)'(1);
		if (size_cfg == '0) begin
			size_c = CW'(1);
		end else if (CW'(size_cfg) > CW'(MAX_SIZE)) begin
			size_c = CW'(MAX_SIZE);
		end else begin
			size_c = CW'(size_cfg);
		end
		lim = size_c - CW'(1);
		lim_ext = (IPART_W + 1)'(lim);
	end

	always_ff @(posedge clk) begin
		idx0 <= ({1'b0, ipart} < lim_ext) ? ipart[IDX_W-1:0] : lim[IDX_W-1:0];
		idx1 <= (ipart_inc < lim_ext) ? ipart_inc[IDX_W-1:0] : lim[IDX_W-1:0];
		frac <= fpart;
	end

endmodule

// ===== rtl/core/brn_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brn_blend
// Four-stage bilinear blend of four RGB neighbors with Q0.16 normalization,
// one lane per color channel.
// ----------------------------------------------------------------------------
module brn_blend import brn_pkg::*; (
	input  logic              clk,
	input  logic [PIX_W-1:0]  p00,
	input  logic [PIX_W-1:0]  p01,
	input  logic [PIX_W-1:0]  p10,
	input  logic [PIX_W-1:0]  p11,
	input  logic [FRAC_W-1:0] fx,
	input  logic [FRAC_W-1:0] fy,
	output logic [FRAC_W-1:0] red_norm,
	output logic [FRAC_W-1:0] green_norm,
	output logic [FRAC_W-1:0] blue_norm
);

	localparam int W_W    = FRAC_W + 1;
	localparam int PROD_W = CH_W + W_W;
	localparam int ACC_W  = CH_W + 2 * FRAC_W;
	localparam int V_W    = CH_W + FRAC_W;
	localparam int N_W    = 2 * FRAC_W;

	logic [W_W-1:0]    wx0;
	logic [W_W-1:0]    wy0;
	logic [FRAC_W-1:0] norm_w [3];

	assign wx0 = ONE_Q16 - W_W'(fx);
	assign wy0 = ONE_Q16 - W_W'(fy);

	for (genvar k = 0; k < 3; k++) begin : g_lane
		logic [CH_W-1:0]   c00, c01, c10, c11;
		logic [PROD_W-1:0] top_s1, bot_s1;
		logic [ACC_W-1:0]  v32_s2;
		logic [V_W-1:0]    v_s3;
		logic [FRAC_W-1:0] norm_s4;

		assign c00 = p00[PIX_W-1-CH_W*k -: CH_W];
		assign c01 = p01[PIX_W-1-CH_W*k -: CH_W];
		assign c10 = p10[PIX_W-1-CH_W*k -: CH_W];
		assign c11 = p11[PIX_W-1-CH_W*k -: CH_W];

		always_ff @(posedge clk) begin
			top_s1 <= PROD_W'(c00) * PROD_W'(wx0) + PROD_W'(c01) * PROD_W'(fx);
			bot_s1 <= PROD_W'(c10) * PROD_W'(wx0) + PROD_W'(c11) * PROD_W'(fx);
			v32_s2 <= ACC_W'(top_s1) * ACC_W'(wy0) + ACC_W'(bot_s1) * ACC_W'(fy);
			v_s3 <= V_W'((v32_s2 + ACC_W'(HALF_Q16)) >> FRAC_W);
			norm_s4 <= FRAC_W'((N_W'(v_s3) * N_W'(NORM_SCALE) + N_W'(HALF_Q16)) >> FRAC_W);
		end

		assign norm_w[k] = norm_s4;
	end

	assign red_norm   = norm_w[0];
	assign green_norm = norm_w[1];
	assign blue_norm  = norm_w[2];

endmodule

// ===== rtl/core/bilinear_resize_normalize_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_resize_normalize_core
// Frame store with bilinear resampling and Q0.16 normalization of RGB pixels.
// ----------------------------------------------------------------------------
// The input channel carries two kinds of transaction. A write transaction
// (cmd low) stores one RGB pixel in the frame store and produces no result.
// A compute transaction (cmd high) names an output pixel and produces one
// result on the output channel: the plane index, three normalized channels
// and a status bit that is set when the pixel lies outside the target size.
// A write transaction does not stall the input channel. A compute transaction
// keeps the input channel stalled through coordinate mapping (MAP1, MAP2),
// the four neighbor reads through the single frame-store read port, four
// blend stages and the hand-over of the result to the output register. An
// outside pixel goes straight from acceptance to the hand-over.
// The output register decouples the channels, so the next transaction is
// accepted while a result still waits. If the receiver stalls for longer,
// the block holds the following result until the output register is free.
// Reset clears the control state and loads the register defaults; the frame
// store contents stay undefined until written. Configuration is to be written
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module bilinear_resize_normalize_core import brn_pkg::*; #(
	parameter int MAX_SRC_WIDTH   = 128,
	parameter int MAX_SRC_HEIGHT  = 128,
	parameter int MAX_TARGET_SIDE = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 cmd,
	input  logic [LOAD_W-1:0]    load_col,
	input  logic [LOAD_W-1:0]    load_row,
	input  logic [CH_W-1:0]      red_in,
	input  logic [CH_W-1:0]      green_in,
	input  logic [CH_W-1:0]      blue_in,
	input  logic [QUERY_W-1:0]   query_col,
	input  logic [QUERY_W-1:0]   query_row,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PLANE_W-1:0]   plane_index,
	output logic [FRAC_W-1:0]    red_norm,
	output logic [FRAC_W-1:0]    green_norm,
	output logic [FRAC_W-1:0]    blue_norm,
	output logic                 status
);

	localparam int XW = $clog2(MAX_SRC_WIDTH);
	localparam int YW = $clog2(MAX_SRC_HEIGHT);
	localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int AW = $clog2(DEPTH);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MAP1  = 6'b000010,
		ST_MAP2  = 6'b000100,
		ST_READ  = 6'b001000,
		ST_BLEND = 6'b010000,
		ST_DONE  = 6'b100000
	} seq_state_t;

	seq_state_t state_q;
	logic [2:0] cnt_q;

	logic [SIZE_W-1:0]  src_w_q, src_h_q;
	logic [TGT_W-1:0]   tgt_cols_q, tgt_rows_q;
	logic [RATIO_W-1:0] col_ratio_q, row_ratio_q;

	logic [TGT_W-1:0]   tc, tr;
	logic               in_accept;
	logic               outside;
	logic               wr_ok;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [AW-1:0]      ram_raddr;
	logic [PIX_W-1:0]   ram_rdata;

	logic [QUERY_W-1:0] qc_q, qr_q;
	logic               outside_q;
	logic [PLANE_W-1:0] plane_q;
	logic [XW-1:0]      x0, x1;
	logic [YW-1:0]      y0, y1;
	logic [FRAC_W-1:0]  fx, fy;
	logic [XW-1:0]      rd_x;
	logic [YW-1:0]      rd_y;
	logic [PIX_W-1:0]   p00_q, p01_q, p10_q, p11_q;
	logic [FRAC_W-1:0]  red_b, green_b, blue_b;
	logic               out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q     <= SIZE_W'(128);
			src_h_q     <= SIZE_W'(128);
			tgt_cols_q  <= TGT_W'(128);
			tgt_rows_q  <= TGT_W'(128);
			col_ratio_q <= RATIO_W'(65536);
			row_ratio_q <= RATIO_W'(65536);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOURCE_WIDTH:  src_w_q     <= cfg_data[SIZE_W-1:0];
				REG_SOURCE_HEIGHT: src_h_q     <= cfg_data[SIZE_W-1:0];
				REG_TARGET_COLS:   tgt_cols_q  <= cfg_data[TGT_W-1:0];
				REG_TARGET_ROWS:   tgt_rows_q  <= cfg_data[TGT_W-1:0];
				REG_COL_RATIO:     col_ratio_q <= cfg_data[RATIO_W-1:0];
				REG_ROW_RATIO:     row_ratio_q <= cfg_data[RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		tc = (32'(tgt_cols_q) > 32'(MAX_TARGET_SIDE)) ? TGT_W'(MAX_TARGET_SIDE) : tgt_cols_q;
		tr = (32'(tgt_rows_q) > 32'(MAX_TARGET_SIDE)) ? TGT_W'(MAX_TARGET_SIDE) : tgt_rows_q;
		outside = (TGT_W'(query_col) >= tc) || (TGT_W'(query_row) >= tr);
		wr_ok = (32'(load_col) < 32'(MAX_SRC_WIDTH)) && (32'(load_row) < 32'(MAX_SRC_HEIGHT));
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign ram_we    = in_accept && (cmd == CMD_WRITE) && wr_ok;
	assign ram_waddr = AW'(32'(load_row) * 32'(MAX_SRC_WIDTH) + 32'(load_col));

	always_comb begin
		rd_x = cnt_q[0] ? x1 : x0;
		rd_y = cnt_q[1] ? y1 : y0;
	end

	assign ram_raddr = AW'(32'(rd_y) * 32'(MAX_SRC_WIDTH) + 32'(rd_x));

	brn_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_frame (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata({red_in, green_in, blue_in}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	brn_axis #(
		.MAX_SIZE(MAX_SRC_WIDTH)
	) u_axis_col (
		.clk     (clk),
		.q       (qc_q),
		.ratio   (col_ratio_q),
		.size_cfg(src_w_q),
		.idx0    (x0),
		.idx1    (x1),
		.frac    (fx)
	);

	brn_axis #(
		.MAX_SIZE(MAX_SRC_HEIGHT)
	) u_axis_row (
		.clk     (clk),
		.q       (qr_q),
		.ratio   (row_ratio_q),
		.size_cfg(src_h_q),
		.idx0    (y0),
		.idx1    (y1),
		.frac    (fy)
	);

	brn_blend u_blend (
		.clk       (clk),
		.p00       (p00_q),
		.p01       (p01_q),
		.p10       (p10_q),
		.p11       (p11_q),
		.fx        (fx),
		.fy        (fy),
		.red_norm  (red_b),
		.green_norm(green_b),
		.blue_norm (blue_b)
	);

	assign out_load = (state_q == ST_DONE) && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept && (cmd == CMD_COMPUTE)) begin
						state_q <= outside ? ST_DONE : ST_MAP1;
					end
				end
				ST_MAP1: begin
					state_q <= ST_MAP2;
				end
				ST_MAP2: begin
					state_q <= ST_READ;
					cnt_q   <= '0;
				end
				ST_READ: begin
					if (cnt_q == 3'd4) begin
						state_q <= ST_BLEND;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_BLEND: begin
					if (cnt_q == 3'd3) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && (cmd == CMD_COMPUTE)) begin
			qc_q      <= query_col;
			qr_q      <= query_row;
			outside_q <= outside;
		end
		if (state_q == ST_MAP1) begin
			plane_q <= PLANE_W'(32'(qr_q) * 32'(tc) + 32'(qc_q));
		end
		if (state_q == ST_READ) begin
			case (cnt_q)
				3'd1:    p00_q <= ram_rdata;
				3'd2:    p01_q <= ram_rdata;
				3'd3:    p10_q <= ram_rdata;
				3'd4:    p11_q <= ram_rdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (outside_q) begin
				plane_index <= '0;
				red_norm    <= '0;
				green_norm  <= '0;
				blue_norm   <= '0;
				status      <= 1'b1;
			end else begin
				plane_index <= plane_q;
				red_norm    <= red_b;
				green_norm  <= green_b;
				blue_norm   <= blue_b;
				status      <= 1'b0;
			end
		end
	end

endmodule

// ===== sim/bilinear_resize_normalize_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_resize_normalize_core_tb
// Self-checking bench for the bilinear resize and normalize core.
// ----------------------------------------------------------------------------
// Source pixels are loaded into the frame store and output pixels are then
// requested under a series of register settings. Every accepted transaction
// is also applied to a behavioral model of the core. Each result is checked
// against the model's oldest pending prediction. Both channels idle at random
// except in the final test, and one long output hold backs the core up into its input.
// ----------------------------------------------------------------------------
module bilinear_resize_normalize_core_tb;
	import brn_pkg::*;

	localparam int MAX_SRC_WIDTH    = 128;
	localparam int MAX_SRC_HEIGHT   = 128;
	localparam int MAX_TARGET_SIDE  = 1024;
	localparam int SETTLE_CYCLES    = 20;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int RUN_LIMIT_NS     = 2_000_000;

	localparam logic [CFG_IDX_W-1:0] REG_RESERVED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RESERVED_HI = 3'd7;

	typedef struct packed {
		logic               cmd;
		logic [LOAD_W-1:0]  load_col;
		logic [LOAD_W-1:0]  load_row;
		logic [CH_W-1:0]    red;
		logic [CH_W-1:0]    green;
		logic [CH_W-1:0]    blue;
		logic [QUERY_W-1:0] query_col;
		logic [QUERY_W-1:0] query_row;
	} pixel_txn_t;

	localparam int TXN_W = $bits(pixel_txn_t);

	typedef struct packed {
		logic [PLANE_W-1:0] plane_index;
		logic [FRAC_W-1:0]  red_norm;
		logic [FRAC_W-1:0]  green_norm;
		logic [FRAC_W-1:0]  blue_norm;
		logic               status;
	} norm_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 cmd;
	logic [LOAD_W-1:0]    load_col;
	logic [LOAD_W-1:0]    load_row;
	logic [CH_W-1:0]      red_in;
	logic [CH_W-1:0]      green_in;
	logic [CH_W-1:0]      blue_in;
	logic [QUERY_W-1:0]   query_col;
	logic [QUERY_W-1:0]   query_row;
	logic                 out_valid;
	logic                 out_stall;
	logic [PLANE_W-1:0]   plane_index;
	logic [FRAC_W-1:0]    red_norm;
	logic [FRAC_W-1:0]    green_norm;
	logic [FRAC_W-1:0]    blue_norm;
	logic                 status;

	longint unsigned cur_src_width   = 128;
	longint unsigned cur_src_height  = 128;
	longint unsigned cur_target_cols = 128;
	longint unsigned cur_target_rows = 128;
	longint unsigned cur_col_ratio   = 65536;
	longint unsigned cur_row_ratio   = 65536;
	logic [PIX_W-1:0] source_pixels [MAX_SRC_WIDTH * MAX_SRC_HEIGHT];
	norm_result_t     pending_pixels [$];

	int error_count   = 0;
	bit random_idling = 1'b1;
	bit hold_request  = 1'b0;

	bilinear_resize_normalize_core #(
		.MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
		.MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
		.MAX_TARGET_SIDE(MAX_TARGET_SIDE)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.load_col   (load_col),
		.load_row   (load_row),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.query_col  (query_col),
		.query_row  (query_row),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.plane_index(plane_index),
		.red_norm   (red_norm),
		.green_norm (green_norm),
		.blue_norm  (blue_norm),
		.status     (status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned clip_target(input longint unsigned side);
		return (side > MAX_TARGET_SIDE) ? MAX_TARGET_SIDE : side;
	endfunction

	function automatic longint unsigned clip_source(input longint unsigned side,
			input longint unsigned limit);
		if (side == 0) begin
			return 1;
		end
		return (side > limit) ? limit : side;
	endfunction

	function automatic void locate_neighbours(input longint unsigned q, ratio, span,
			output longint unsigned lo, hi, weight);
		longint unsigned t;
		longint unsigned idx;
		t = (2 * q + 1) * ratio;
		idx = 0;
		weight = 0;
		if (t >= ONE_Q16) begin
			idx = ((t - ONE_Q16) >> 1) >> FRAC_W;
			weight = ((t - ONE_Q16) >> 1) & 16'hFFFF;
		end
		lo = (idx < span - 1) ? idx : span - 1;
		hi = (idx + 1 < span - 1) ? idx + 1 : span - 1;
	endfunction

	function automatic norm_result_t resample_pixel(input pixel_txn_t tx);
		longint unsigned cols, rows, x0, x1, fx, y0, y1, fy, top, bot, v;
		longint unsigned px [4];
		longint unsigned ch [4];
		logic [FRAC_W-1:0] norm [3];
		norm_result_t res;
		res = '0;
		cols = clip_target(cur_target_cols);
		rows = clip_target(cur_target_rows);
		if (tx.query_col >= cols || tx.query_row >= rows) begin
			res.status = 1'b1;
			return res;
		end
		locate_neighbours(tx.query_col, cur_col_ratio,
			clip_source(cur_src_width, MAX_SRC_WIDTH), x0, x1, fx);
		locate_neighbours(tx.query_row, cur_row_ratio,
			clip_source(cur_src_height, MAX_SRC_HEIGHT), y0, y1, fy);
		px[0] = source_pixels[y0 * MAX_SRC_WIDTH + x0];
		px[1] = source_pixels[y0 * MAX_SRC_WIDTH + x1];
		px[2] = source_pixels[y1 * MAX_SRC_WIDTH + x0];
		px[3] = source_pixels[y1 * MAX_SRC_WIDTH + x1];
		for (int k = 0; k < 3; k++) begin
			for (int n = 0; n < 4; n++) begin
				ch[n] = (px[n] >> ((2 - k) * CH_W)) & 8'hFF;
			end
			top = ch[0] * (ONE_Q16 - fx) + ch[1] * fx;
			bot = ch[2] * (ONE_Q16 - fx) + ch[3] * fx;
			v = (top * (ONE_Q16 - fy) + bot * fy + HALF_Q16) >> FRAC_W;
			norm[k] = FRAC_W'((v * NORM_SCALE + HALF_Q16) >> FRAC_W);
		end
		res.plane_index = PLANE_W'(tx.query_row * cols + tx.query_col);
		res.red_norm = norm[0];
		res.green_norm = norm[1];
		res.blue_norm = norm[2];
		return res;
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] value);
		case (idx)
			REG_SOURCE_WIDTH: cur_src_width = value[SIZE_W-1:0];
			REG_SOURCE_HEIGHT: cur_src_height = value[SIZE_W-1:0];
			REG_TARGET_COLS: cur_target_cols = value[TGT_W-1:0];
			REG_TARGET_ROWS: cur_target_rows = value[TGT_W-1:0];
			REG_COL_RATIO: cur_col_ratio = value[RATIO_W-1:0];
			REG_ROW_RATIO: cur_row_ratio = value[RATIO_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void report_failure(input string what);
		if (error_count < 10) begin
			$display("%0t ns: %s", $time, what);
		end
		error_count++;
	endfunction

	always @(posedge clk) begin : track_inputs
		pixel_txn_t tx;
		if (arst_n) begin
			if (cfg_we) begin
				apply_register(cfg_index, cfg_data);
			end
			if (in_valid && !in_stall) begin
				tx = '{cmd, load_col, load_row, red_in, green_in, blue_in, query_col, query_row};
				if (tx.cmd == CMD_WRITE) begin
					source_pixels[tx.load_row * MAX_SRC_WIDTH + tx.load_col] =
						{tx.red, tx.green, tx.blue};
				end else begin
					pending_pixels.push_back(resample_pixel(tx));
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		norm_result_t got;
		norm_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{plane_index, red_norm, green_norm, blue_norm, status};
			if (pending_pixels.size() == 0) begin
				report_failure($sformatf("unexpected result: index %0d norms %h %h %h status %0d",
					got.plane_index, got.red_norm, got.green_norm, got.blue_norm, got.status));
			end else begin
				want = pending_pixels.pop_front();
				if (got !== want) begin
					report_failure($sformatf(
						"mismatch: expected index %0d norms %h %h %h status %0d, got index %0d norms %h %h %h status %0d",
						want.plane_index, want.red_norm, want.green_norm, want.blue_norm,
						want.status, got.plane_index, got.red_norm, got.green_norm,
						got.blue_norm, got.status));
				end
			end
		end
	end

	// The long hold is requested by the backpressure test and timed here, so the
	// sender keeps offering transactions while the output stays blocked.
	initial begin : receiver_stalls
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (random_idling && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("FAILURE");
		$finish;
	end

	function automatic pixel_txn_t write_item(input int unsigned col, row,
			input logic [PIX_W-1:0] rgb);
		pixel_txn_t tx;
		tx = TXN_W'({$urandom, $urandom});
		tx.cmd = CMD_WRITE;
		tx.load_col = LOAD_W'(col);
		tx.load_row = LOAD_W'(row);
		{tx.red, tx.green, tx.blue} = rgb;
		return tx;
	endfunction

	function automatic pixel_txn_t compute_item(input int unsigned col, row);
		pixel_txn_t tx;
		tx = TXN_W'({$urandom, $urandom});
		tx.cmd = CMD_COMPUTE;
		tx.query_col = QUERY_W'(col);
		tx.query_row = QUERY_W'(row);
		return tx;
	endfunction

	task automatic send_item(input pixel_txn_t tx);
		if (random_idling && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= tx.cmd;
		load_col <= tx.load_col;
		load_row <= tx.load_row;
		red_in <= tx.red;
		green_in <= tx.green;
		blue_in <= tx.blue;
		query_col <= tx.query_col;
		query_row <= tx.query_row;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic configure(input logic [CFG_W-1:0] src_w, src_h, tgt_c, tgt_r,
			c_ratio, r_ratio, input bit poke_reserved);
		settle();
		write_register(REG_SOURCE_WIDTH, src_w);
		write_register(REG_SOURCE_HEIGHT, src_h);
		write_register(REG_TARGET_COLS, tgt_c);
		write_register(REG_TARGET_ROWS, tgt_r);
		write_register(REG_COL_RATIO, c_ratio);
		write_register(REG_ROW_RATIO, r_ratio);
		if (poke_reserved) begin
			write_register(REG_RESERVED_LO, CFG_W'($urandom));
			write_register(REG_RESERVED_HI, '0);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic fill_source_image();
		int unsigned cols;
		int unsigned rows;
		cols = 32'(clip_source(cur_src_width, MAX_SRC_WIDTH));
		rows = 32'(clip_source(cur_src_height, MAX_SRC_HEIGHT));
		for (int r = 0; r < rows; r++) begin
			for (int c = 0; c < cols; c++) begin
				send_item(write_item(c, r, PIX_W'($urandom)));
			end
		end
	endtask

	task automatic random_traffic(input int count);
		int unsigned cols;
		int unsigned rows;
		int unsigned qc;
		int unsigned qr;
		bit hits_target;
		bit can_miss;
		cols = 32'(clip_target(cur_target_cols));
		rows = 32'(clip_target(cur_target_rows));
		hits_target = (cols != 0) && (rows != 0);
		can_miss = (cols < MAX_TARGET_SIDE) || (rows < MAX_TARGET_SIDE);
		repeat (count) begin
			if ($urandom_range(0, 99) < 25) begin
				send_item(write_item($urandom_range(0, MAX_SRC_WIDTH - 1),
					$urandom_range(0, MAX_SRC_HEIGHT - 1), PIX_W'($urandom)));
			end else if (!hits_target || (can_miss && $urandom_range(0, 99) < 12)) begin
				if (cols < MAX_TARGET_SIDE && (rows >= MAX_TARGET_SIDE || $urandom_range(0, 1))) begin
					qc = $urandom_range(cols, MAX_TARGET_SIDE - 1);
					qr = $urandom_range(0, MAX_TARGET_SIDE - 1);
				end else begin
					qc = $urandom_range(0, MAX_TARGET_SIDE - 1);
					qr = $urandom_range(rows, MAX_TARGET_SIDE - 1);
				end
				send_item(compute_item(qc, qr));
			end else begin
				send_item(compute_item($urandom_range(0, cols - 1), $urandom_range(0, rows - 1)));
			end
		end
	endtask

	// Default registers: unit ratio over a 128 by 128 source, corners only.
	task automatic test_reset_defaults();
		send_item(write_item(0, 0, 24'h000000));
		send_item(write_item(1, 0, 24'hFFFFFF));
		send_item(write_item(0, 1, 24'hFF00FF));
		send_item(write_item(1, 1, 24'h00FF00));
		send_item(write_item(126, 126, 24'h123456));
		send_item(write_item(127, 126, 24'hFFFFFF));
		send_item(write_item(126, 127, 24'h000000));
		send_item(write_item(127, 127, 24'h80FF01));
		send_item(compute_item(0, 0));
		send_item(compute_item(126, 126));
		send_item(compute_item(127, 127));
		send_item(compute_item(128, 0));
		send_item(compute_item(0, 128));
		send_item(compute_item(1023, 1023));
	endtask

	// Half ratio on a 2 by 2 source: negative positions, quarter weights and
	// positions past the far edge.
	task automatic test_edge_weights();
		configure(2, 2, 4, 4, 24'd32768, 24'd32768, 1'b0);
		send_item(write_item(0, 0, 24'hFF0000));
		send_item(write_item(1, 0, 24'h00FF00));
		send_item(write_item(0, 1, 24'h0000FF));
		send_item(write_item(1, 1, 24'hFFFFFF));
		send_item(compute_item(0, 0));
		send_item(compute_item(1, 1));
		send_item(compute_item(3, 3));
		send_item(compute_item(2, 0));
		send_item(compute_item(0, 3));
	endtask

	task automatic test_upscale();
		configure(8, 6, 20, 15, 24'd26214, 24'd26214, 1'b0);
		fill_source_image();
		random_traffic(100);
	endtask

	task automatic test_single_column_source();
		configure(1, 128, 1, 1024, 24'd0, 24'd8192, 1'b0);
		fill_source_image();
		random_traffic(90);
	endtask

	task automatic test_single_row_source();
		configure(128, 1, 1024, 1, 24'd8192, 24'd8388608, 1'b0);
		fill_source_image();
		random_traffic(90);
	endtask

	task automatic test_zero_sizes();
		configure(0, 0, 0, 300, CFG_W'($urandom_range(0, 24'h3FFFF)),
			CFG_W'($urandom_range(0, 24'h3FFFF)), 1'b0);
		fill_source_image();
		random_traffic(30);
	endtask

	// Source width and target sizes above their limits, with stray bits above each
	// size register's width and writes to the unused register indexes.
	task automatic test_oversized_config();
		configure({16'hA5C3, 8'd255}, {16'h3C5A, 8'd2}, {13'h1ACE, 11'h7FF},
			{13'h0F0F, 11'd1500}, CFG_W'($urandom_range(0, 24'h1FFFF)),
			CFG_W'($urandom_range(0, 24'h1FFFF)), 1'b1);
		fill_source_image();
		random_traffic(100);
	endtask

	task automatic test_random_ratios();
		configure(16, 16, 64, 48, CFG_W'($urandom_range(0, 24'h3FFFF)),
			CFG_W'($urandom_range(0, 24'hFFFFFF)), 1'b0);
		fill_source_image();
		random_traffic(200);
	endtask

	task automatic test_backpressure();
		configure(4, 4, 32, 32, 24'd8192, 24'd8192, 1'b0);
		fill_source_image();
		hold_request = 1'b1;
		random_traffic(100);
	endtask

	task automatic test_no_idle();
		random_idling = 1'b0;
		configure(12, 10, 40, 40, 24'd19661, 24'd16384, 1'b0);
		fill_source_image();
		random_traffic(175);
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SOURCE_WIDTH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		cmd <= CMD_WRITE;
		load_col <= '0;
		load_row <= '0;
		red_in <= '0;
		green_in <= '0;
		blue_in <= '0;
		query_col <= '0;
		query_row <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_edge_weights();
		test_upscale();
		test_single_column_source();
		test_single_row_source();
		test_zero_sizes();
		test_oversized_config();
		test_random_ratios();
		test_backpressure();
		test_no_idle();
		settle();
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
